// ----- design/uakx_pkg.sv -----
// Package: shared constants for the UTF-8 autokey XOR cipher.
package uakx_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned KEY_W = 35;
  localparam int unsigned KCH_W = 7;
  localparam int unsigned NUM_KEY_CHARS = 10;

  localparam logic [CP_W-1:0] CIPHER_OFFSET = 21'h003061;
  localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;

  // Result status codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_RANGE     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_KEY_HIGH = 2'd2;

  // Mode register values.
  localparam logic MODE_ENCRYPT = 1'b0;

endpackage

// ----- design/uakx_in_if.sv -----
// Interface: input byte channel with valid/ready handshake.
interface uakx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_of_message;

  modport source (output valid, output byte_in, output start_of_message, input ready);
  modport sink   (input valid, input byte_in, input start_of_message, output ready);
endinterface

// ----- design/uakx_out_if.sv -----
// Interface: output byte channel with valid/ready handshake.
interface uakx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_byte;
  logic [1:0] error_code;

  modport source (output valid, output byte_out, output last_byte, output error_code,
                  input ready);
  modport sink   (input valid, input byte_out, input last_byte, input error_code,
                  output ready);
endinterface

// ----- design/utf8_autokey_xor_cipher.sv -----
// Top level: UTF-8 autokey XOR cipher with a history memory and byte serializer.
//
// Bytes of a UTF-8 message enter on in_stream, one per transaction, and leave on
// out_stream as the UTF-8 encoding of each transformed codepoint, one byte per
// transaction, with last_byte on the final byte. A byte that does not complete
// a codepoint yields nothing; a malformed byte, a decrypt input below 0x3061 or
// a result above 0x10FFFF yields a single zero byte with last_byte set and the
// error code. The path is decode, history read, transform, serialize: the byte
// that completes a codepoint is registered into stage B, then stage C, then the
// serializer, and any of them can be held by back-pressure from out_stream.
// Throughput is set by the output serializer, one byte per cycle while
// out_stream is ready: each codepoint occupies it for every byte of its
// encoding (one to four), and it loads the next as the last leaves. The plaintext
// history sits in a HISTORY_DEPTH-entry memory with a registered read port;
// it needs no clearing pass after reset, since an entry is read only after it
// was written in the current message. The read-modify-write on the history is
// covered by steering the read address past a slot that is being written in
// the same cycle, plus a forwarding register when the two still collide (a
// one-entry history). Write mode and key registers only while the block is
// idle; cfg_index selects mode, key characters 0-4, or key characters 5-9.
module utf8_autokey_xor_cipher #(
  parameter int unsigned HISTORY_DEPTH = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [uakx_pkg::KEY_W-1:0]  cfg_data,
  uakx_in_if.sink                     in_stream,
  uakx_out_if.source                  out_stream
);

  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned POS_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CP_W   = uakx_pkg::CP_W;
  localparam int unsigned KCH_W  = uakx_pkg::KCH_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                       mode;
  logic [uakx_pkg::KEY_W-1:0] key_low;
  logic [uakx_pkg::KEY_W-1:0] key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= uakx_pkg::MODE_ENCRYPT;
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        uakx_pkg::REG_MODE:     mode     <= cfg_data[0];
        uakx_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        uakx_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Key characters laid out by position; positions past the tenth read zero.
  logic [KCH_W-1:0] key_chars [2**POS_W];

  for (genvar i = 0; i < 2**POS_W; i++) begin : g_key
    if (i < 5) begin : g_low
      assign key_chars[i] = key_low[KCH_W*i +: KCH_W];
    end else if (i < uakx_pkg::NUM_KEY_CHARS) begin : g_high
      assign key_chars[i] = key_high[KCH_W*(i-5) +: KCH_W];
    end else begin : g_none
      assign key_chars[i] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control across the three stages
  // ---------------------------------------------------------------------------
  logic       b_v;          // decoded item waiting for its history read
  logic       c_v;          // item with read data, ready to transform
  logic [2:0] ser_left;     // bytes still to send from the serializer
  logic       ser_can_load;
  logic       c_fire;
  logic       b_go;
  logic       in_fire;
  logic       out_fire;

  assign out_fire     = out_stream.valid && out_stream.ready;
  // The serializer takes a new codepoint once its last byte leaves.
  assign ser_can_load = (ser_left == 3'd0) || ((ser_left == 3'd1) && out_stream.ready);
  assign c_fire       = c_v && ser_can_load;
  assign b_go         = b_v && (!c_v || c_fire);
  assign in_stream.ready = !b_v || b_go;
  assign in_fire      = in_stream.valid && in_stream.ready;

  // ---------------------------------------------------------------------------
  // Stage A: UTF-8 decode at accept
  // ---------------------------------------------------------------------------
  logic [CP_W-1:0] dec_acc;
  logic [1:0]      cont_left;
  logic            restart_pend;  // start of message seen, not yet handed down

  logic [CP_W-1:0] dec_acc_next;
  logic [1:0]      cont_left_next;
  logic            item_emit;
  logic            item_err;
  logic [CP_W-1:0] item_cp;
  logic [CP_W-1:0] acc_eff;
  logic [1:0]      cont_eff;
  logic [CP_W-1:0] acc_shift;
  logic [7:0]      bin;

  always_comb begin
    bin       = in_stream.byte_in;
    acc_eff   = in_stream.start_of_message ? '0 : dec_acc;
    cont_eff  = in_stream.start_of_message ? 2'd0 : cont_left;
    acc_shift = {acc_eff[CP_W-7:0], bin[5:0]};

    dec_acc_next   = acc_eff;
    cont_left_next = cont_eff;
    item_emit      = 1'b0;
    item_err       = 1'b0;
    item_cp        = {{(CP_W-8){1'b0}}, bin};

    if (cont_eff == 2'd0) begin
      if (bin[7] == 1'b0) begin
        item_emit = 1'b1;
      end else if (bin[7:5] == 3'b110) begin
        dec_acc_next   = {{(CP_W-5){1'b0}}, bin[4:0]};
        cont_left_next = 2'd1;
      end else if (bin[7:4] == 4'b1110) begin
        dec_acc_next   = {{(CP_W-4){1'b0}}, bin[3:0]};
        cont_left_next = 2'd2;
      end else if (bin[7:3] == 5'b11110) begin
        dec_acc_next   = {{(CP_W-3){1'b0}}, bin[2:0]};
        cont_left_next = 2'd3;
      end else begin
        // Stray continuation byte or an impossible lead: emit an error item.
        item_emit = 1'b1;
        item_err  = 1'b1;
      end
    end else if (bin[7:6] != 2'b10) begin
      // Broken sequence: drop the partial codepoint and this byte, emit an error item.
      dec_acc_next   = '0;
      cont_left_next = 2'd0;
      item_emit      = 1'b1;
      item_err       = 1'b1;
    end else begin
      cont_left_next = cont_eff - 2'd1;
      dec_acc_next   = acc_shift;
      if (cont_eff == 2'd1) begin
        item_emit    = 1'b1;
        item_cp      = acc_shift;
        dec_acc_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_acc      <= '0;
      cont_left    <= 2'd0;
      restart_pend <= 1'b0;
    end else if (in_fire) begin
      dec_acc      <= dec_acc_next;
      cont_left    <= cont_left_next;
      // Carry the restart down with the next item so items in flight keep
      // their position and slot.
      restart_pend <= !item_emit && (restart_pend || in_stream.start_of_message);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: history read
  // ---------------------------------------------------------------------------
  logic            b_err;
  logic            b_sop;
  logic [CP_W-1:0] b_cp;

  logic            c_err;
  logic            c_sop;
  logic [CP_W-1:0] c_cp;

  logic [CP_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [CP_W-1:0] rd_q;
  logic            fwd_hit;
  logic [CP_W-1:0] fwd_data;

  logic [SLOT_W-1:0] slot;
  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] slot_eff;
  logic [POS_W-1:0]  pos_eff;
  logic [SLOT_W-1:0] slot_next;
  logic [POS_W-1:0]  pos_next;
  logic [SLOT_W-1:0] rd_addr;
  logic              c_ok;
  logic [CP_W-1:0]   c_plain;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (in_fire && item_emit) begin
      b_v <= 1'b1;
    end else if (b_go) begin
      b_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && item_emit) begin
      b_err <= item_err;
      b_sop <= restart_pend || in_stream.start_of_message;
      b_cp  <= item_cp;
    end
  end

  // Read the slot that will be current once stage C has retired its item.
  always_comb begin
    if (b_sop) begin
      rd_addr = '0;
    end else if (c_fire) begin
      rd_addr = slot_next;
    end else begin
      rd_addr = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      rd_q     <= hist_mem[rd_addr];
      fwd_hit  <= c_fire && c_ok && (rd_addr == slot_eff);
      fwd_data <= c_plain;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire && c_ok) begin
      hist_mem[slot_eff] <= c_plain;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: transform, range check, history write-back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (b_go) begin
      c_v <= 1'b1;
    end else if (c_fire) begin
      c_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      c_err <= b_err;
      c_sop <= b_sop;
      c_cp  <= b_cp;
    end
  end

  logic [CP_W-1:0] hist_val;
  logic [CP_W-1:0] src;
  logic [CP_W:0]   enc_sum;
  logic [CP_W-1:0] dec_val;
  logic [CP_W-1:0] res;
  logic [1:0]      c_code;

  always_comb begin
    slot_eff = c_sop ? '0 : slot;
    pos_eff  = c_sop ? '0 : pos;
    hist_val = fwd_hit ? fwd_data : rd_q;

    if (pos_eff < POS_W'(HISTORY_DEPTH)) begin
      src = {{(CP_W-KCH_W){1'b0}}, key_chars[pos_eff]};
    end else begin
      src = hist_val;
    end

    enc_sum = {1'b0, c_cp ^ src} + {1'b0, uakx_pkg::CIPHER_OFFSET};
    dec_val = (c_cp - uakx_pkg::CIPHER_OFFSET) ^ src;

    if (c_err) begin
      c_code  = uakx_pkg::ERR_MALFORMED;
      res     = dec_val;
      c_plain = dec_val;
    end else if (mode == uakx_pkg::MODE_ENCRYPT) begin
      res     = enc_sum[CP_W-1:0];
      c_plain = c_cp;
      c_code  = (enc_sum > {1'b0, uakx_pkg::CP_MAX}) ? uakx_pkg::ERR_RANGE
                                                     : uakx_pkg::ERR_NONE;
    end else begin
      res     = dec_val;
      c_plain = dec_val;
      c_code  = ((c_cp < uakx_pkg::CIPHER_OFFSET) || (dec_val > uakx_pkg::CP_MAX))
                ? uakx_pkg::ERR_RANGE : uakx_pkg::ERR_NONE;
    end

    c_ok = (c_code == uakx_pkg::ERR_NONE);

    // A dropped codepoint leaves slot and position unchanged, or at zero on a restart.
    if (c_ok) begin
      slot_next = (slot_eff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_eff + 1'b1;
      pos_next  = (pos_eff < POS_W'(HISTORY_DEPTH)) ? pos_eff + 1'b1 : pos_eff;
    end else begin
      slot_next = slot_eff;
      pos_next  = pos_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      pos  <= '0;
    end else if (c_fire) begin
      slot <= slot_next;
      pos  <= pos_next;
    end
  end

  // UTF-8 encode of the result; an error is one zero byte.
  logic [7:0] enc_bytes [4];
  logic [2:0] enc_len;

  always_comb begin
    enc_bytes[0] = 8'h00;
    enc_bytes[1] = {2'b10, res[5:0]};
    enc_bytes[2] = {2'b10, res[5:0]};
    enc_bytes[3] = {2'b10, res[5:0]};
    enc_len      = 3'd1;
    if (!c_ok) begin
      enc_bytes[0] = 8'h00;
    end else if (res <= 21'h00007F) begin
      enc_bytes[0] = res[7:0];
    end else if (res <= 21'h0007FF) begin
      enc_bytes[0] = {3'b110, res[10:6]};
      enc_len      = 3'd2;
    end else if (res <= 21'h00FFFF) begin
      enc_bytes[0] = {4'b1110, res[15:12]};
      enc_bytes[1] = {2'b10, res[11:6]};
      enc_len      = 3'd3;
    end else begin
      enc_bytes[0] = {5'b11110, res[20:18]};
      enc_bytes[1] = {2'b10, res[17:12]};
      enc_bytes[2] = {2'b10, res[11:6]};
      enc_len      = 3'd4;
    end
  end

  // ---------------------------------------------------------------------------
  // Output serializer: one byte per transaction, shift on each send
  // ---------------------------------------------------------------------------
  logic [7:0] ser_bytes [4];
  logic [1:0] ser_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_left <= 3'd0;
    end else if (c_fire) begin
      ser_left <= enc_len;
    end else if (out_fire) begin
      ser_left <= ser_left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire) begin
      ser_bytes <= enc_bytes;
      ser_code  <= c_code;
    end else if (out_fire) begin
      ser_bytes[0] <= ser_bytes[1];
      ser_bytes[1] <= ser_bytes[2];
      ser_bytes[2] <= ser_bytes[3];
    end
  end

  assign out_stream.valid      = (ser_left != 3'd0);
  assign out_stream.byte_out   = ser_bytes[0];
  assign out_stream.last_byte  = (ser_left == 3'd1);
  assign out_stream.error_code = ser_code;

endmodule
